/* sv/hse_pkg.sv */
// Package for the hostname scanner: sizes, character codes, register indexes,
// controller state encoding and the command/status structs.
// No dependencies; every other file imports it.
package hse_pkg;

    // Longest hostname that is stored and accepted.
    localparam int MAX_NAME = 253;
    localparam int NAME_W   = 8;
    localparam int WORDS    = (MAX_NAME + 3) / 4;
    localparam int WADDR_W  = $clog2(WORDS);
    localparam int LABEL_W  = 7;
    localparam int MAXL_W   = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [NAME_W-1:0]  MAX_NAME_V = NAME_W'(MAX_NAME);
    localparam logic [LABEL_W-1:0] LABEL_SAT  = 7'd127;
    localparam logic [7:0]         CHAR_DOT    = 8'h2E;
    localparam logic [7:0]         CHAR_HYPHEN = 8'h2D;
    localparam logic [NAME_W-1:0]  MIN_LEN_RESET   = 8'd6;
    localparam logic [MAXL_W-1:0]  MAX_LABEL_RESET = 6'd63;

    // Register indexes, selected by paddr bit 2.
    localparam logic REG_MIN_LEN   = 1'b0;
    localparam logic REG_MAX_LABEL = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_DONE = 5'b00100,
        S_READ = 5'b01000,
        S_SEND = 5'b10000
    } state_t;

    typedef struct packed {
        logic fresh;       // accepted byte starts a new run
        logic in_run;      // accepted byte belongs to a run
        logic accept;      // a request is accepted this cycle
        logic emit_start;  // latch run length and rewind the word pointer
        logic nf_load;     // load the not-found result
        logic word_load;   // load the next hostname word
    } cmd_t;

    typedef struct packed {
        logic letter;
        logic host;
        logic run_ok;
        logic word_last;
    } stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_host(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CHAR_DOT
            || c == CHAR_HYPHEN;
    endfunction

endpackage

/* sv/hse_ifs.sv */
// Stream interfaces for the payload byte channel and the hostname result channel.
// Depends on hse_pkg for field widths.
interface hse_in_if import hse_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface hse_out_if import hse_pkg::*;;
    logic              valid;
    logic              ready;
    logic [31:0]       name_bytes;
    logic [2:0]        byte_count;
    logic [NAME_W-1:0] name_length;
    logic              found;
    logic              run_last;

    modport source (output valid, output name_bytes, output byte_count,
                    output name_length, output found, output run_last, input ready);
    modport sink   (input valid, input name_bytes, input byte_count,
                    input name_length, input found, input run_last, output ready);
endinterface

/* sv/hse_regs.sv */
// APB-style configuration registers: minimum name length and maximum label length.
// Depends on hse_pkg.
module hse_regs import hse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [NAME_W-1:0]   min_len,
    output logic [MAXL_W-1:0]   max_label
);

    logic [NAME_W-1:0] min_len_reg;
    logic [MAXL_W-1:0] max_label_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= MIN_LEN_RESET;
            max_label_reg <= MAX_LABEL_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MIN_LEN:   min_len_reg   <= pwdata[NAME_W-1:0];
                REG_MAX_LABEL: max_label_reg <= pwdata[MAXL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_LEN:   prdata = DATA_W'(min_len_reg);
            REG_MAX_LABEL: prdata = DATA_W'(max_label_reg);
            default:       prdata = '0;
        endcase
    end

    assign min_len   = min_len_reg;
    assign max_label = max_label_reg;

endmodule

/* sv/hse_ctrl.sv */
// Controller: scan phase and emission sequencing, input/output handshakes.
// Depends on hse_pkg; drives the hse_dp datapath through cmd_t.
module hse_ctrl import hse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  buffer_end,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   ret_done_reg, ret_done_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   scanning;

    assign slot_free = !out_valid_reg || out_ready;
    assign scanning  = (state_reg == S_IDLE) || (state_reg == S_RUN) || (state_reg == S_DONE);
    assign in_ready  = scanning && slot_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = in_valid && in_ready;
        cmd.fresh      = (state_reg == S_IDLE) && stat.letter;
        cmd.in_run     = cmd.fresh || (state_reg == S_RUN);
        state_next     = state_reg;
        ret_done_next  = ret_done_reg;

        unique case (state_reg)
            S_IDLE, S_RUN:
            begin
                if (cmd.accept)
                begin
                    if (cmd.in_run && stat.host && !buffer_end)
                    begin
                        state_next = S_RUN;
                    end
                    else if (cmd.in_run && stat.run_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        ret_done_next  = !buffer_end;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        cmd.nf_load = buffer_end;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_DONE:
            begin
                if (cmd.accept && buffer_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (slot_free)
                begin
                    cmd.word_load = 1'b1;
                    if (stat.word_last)
                    begin
                        state_next = ret_done_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.nf_load || cmd.word_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_done_reg  <= ret_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/hse_dp.sv */
// Datapath: run tracking, hostname byte store, word readout and result register.
// Depends on hse_pkg; commanded by hse_ctrl.
module hse_dp import hse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [7:0]        data_byte,
    input  logic [NAME_W-1:0] min_len,
    input  logic [MAXL_W-1:0] max_label,
    output stat_t             stat,
    output logic [31:0]       name_bytes,
    output logic [2:0]        byte_count,
    output logic [NAME_W-1:0] name_length,
    output logic              found,
    output logic              run_last
);

    logic [NAME_W-1:0]  rl_reg, cur_rl, new_rl, ev_rl;
    logic [LABEL_W-1:0] ll_reg, cur_ll, new_ll, ev_ll;
    logic               dot_reg, cur_dot, new_dot, ev_dot;
    logic               fault_reg, cur_fault, new_fault, ev_fault;
    logic               punct_reg, cur_punct, ev_punct;
    logic               host, is_dot, is_punct, upd;
    logic [LABEL_W-1:0] max_label_x;

    logic [31:0]        mem [WORDS];
    logic [31:0]        rd_data_reg;
    logic [WADDR_W-1:0] ptr_reg;
    logic [NAME_W-1:0]  emit_len_reg;
    logic [NAME_W-1:0]  remain;
    logic [2:0]         word_cnt;
    logic [31:0]        word_masked;

    logic [31:0]        name_bytes_reg;
    logic [2:0]         byte_count_reg;
    logic [NAME_W-1:0]  name_length_reg;
    logic               found_reg;
    logic               run_last_reg;

    assign host        = is_host(data_byte);
    assign is_dot      = (data_byte == CHAR_DOT);
    assign is_punct    = is_dot || (data_byte == CHAR_HYPHEN);
    assign max_label_x = LABEL_W'(max_label);
    assign upd         = cmd.accept && cmd.in_run && host;

    // A new run starts from cleared state.
    always_comb
    begin
        cur_rl    = cmd.fresh ? '0 : rl_reg;
        cur_ll    = cmd.fresh ? '0 : ll_reg;
        cur_dot   = cmd.fresh ? 1'b0 : dot_reg;
        cur_fault = cmd.fresh ? 1'b0 : fault_reg;
        cur_punct = cmd.fresh ? 1'b0 : punct_reg;

        new_rl    = (cur_rl <= MAX_NAME_V) ? cur_rl + 1'b1 : cur_rl;
        new_dot   = cur_dot || is_dot;
        new_fault = cur_fault
                 || (is_dot && (cur_ll == '0 || cur_ll > max_label_x));
        if (is_dot)
        begin
            new_ll = '0;
        end
        else if (cur_ll < LABEL_SAT)
        begin
            new_ll = cur_ll + 1'b1;
        end
        else
        begin
            new_ll = cur_ll;
        end

        ev_rl    = host ? new_rl    : cur_rl;
        ev_ll    = host ? new_ll    : cur_ll;
        ev_dot   = host ? new_dot   : cur_dot;
        ev_fault = host ? new_fault : cur_fault;
        ev_punct = host ? is_punct  : cur_punct;
    end

    assign stat.letter = is_letter(data_byte);
    assign stat.host   = host;
    assign stat.run_ok = (ev_rl >= min_len) && (ev_rl <= MAX_NAME_V) && !ev_punct
                      && ev_dot && !ev_fault && (ev_ll != '0) && (ev_ll <= max_label_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rl_reg    <= '0;
            ll_reg    <= '0;
            dot_reg   <= 1'b0;
            fault_reg <= 1'b0;
            punct_reg <= 1'b0;
        end
        else if (upd)
        begin
            rl_reg    <= new_rl;
            ll_reg    <= new_ll;
            dot_reg   <= new_dot;
            fault_reg <= new_fault;
            punct_reg <= is_punct;
        end
    end

    // Byte store: one lane written per run byte below MAX_NAME, one word read a cycle.
    always_ff @(posedge clk)
    begin
        if (upd && cur_rl < MAX_NAME_V)
        begin
            mem[cur_rl[WADDR_W+1:2]][cur_rl[1:0]*8 +: 8] <= data_byte;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.emit_start)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.word_load)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_start)
        begin
            emit_len_reg <= ev_rl;
        end
    end

    assign remain         = emit_len_reg - NAME_W'({ptr_reg, 2'b00});
    assign stat.word_last = (remain <= NAME_W'(4));
    assign word_cnt       = stat.word_last ? remain[2:0] : 3'd4;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            word_masked[j*8 +: 8] = (word_cnt > 3'(j)) ? rd_data_reg[j*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.word_load)
        begin
            name_bytes_reg  <= word_masked;
            byte_count_reg  <= word_cnt;
            name_length_reg <= emit_len_reg;
            found_reg       <= 1'b1;
            run_last_reg    <= stat.word_last;
        end
        else if (cmd.nf_load)
        begin
            name_bytes_reg  <= '0;
            byte_count_reg  <= '0;
            name_length_reg <= '0;
            found_reg       <= 1'b0;
            run_last_reg    <= 1'b1;
        end
    end

    assign name_bytes  = name_bytes_reg;
    assign byte_count  = byte_count_reg;
    assign name_length = name_length_reg;
    assign found       = found_reg;
    assign run_last    = run_last_reg;

endmodule

/* sv/hostname_scan_extract.sv */
// Top level of the hostname scanner: registers, controller and datapath.
// Depends on hse_pkg, hse_ifs, hse_regs, hse_ctrl and hse_dp.
// Usage: payload bytes enter on in_ch, one request per byte, with buffer_end
// set on the final byte of each payload buffer. The block looks for the first
// run that starts at a letter, consists of letters, digits, dots and hyphens,
// and forms a valid DNS-like name. The hostname leaves on out_ch as a burst of
// requests of up to four bytes each (earliest byte in bits 7:0) with the total
// length, found = 1 and run_last on the final word. A buffer without a hostname
// ends with one request with found = 0 and run_last = 1.
// Scanning takes one payload byte per cycle unless a stalled result holds the
// output register. When an accepted run closes, input stalls while the name is
// read back out of the 32-bit-wide byte store, each result word being read in
// S_READ and then loaded into the output register in S_SEND. A not-found result
// is valid in the cycle after the closing byte is accepted; the first hostname
// word goes through S_READ and S_SEND. While the receiver stalls, the result
// waits in the output register and input is refused unless that result is taken
// in the same cycle. Configuration (min_name_length at 0x0, max_label_length at
// 0x4) is written by the user only while idle, not enforced by the block.
// Reset clears the scan state and sets the registers to 6 and 63; the byte
// store needs no clearing because only bytes of the current run are read.
module hostname_scan_extract import hse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    hse_in_if.sink             in_ch,
    hse_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [NAME_W-1:0] min_len;
    logic [MAXL_W-1:0] max_label;
    cmd_t              cmd;
    stat_t             stat;

    // Configuration registers.
    hse_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .min_len   (min_len),
        .max_label (max_label)
    );

    // The controller owns the phase of the scan and both handshakes.
    hse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .buffer_end (in_ch.buffer_end),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath evaluates each byte, stores the run and builds results.
    hse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .min_len     (min_len),
        .max_label   (max_label),
        .stat        (stat),
        .name_bytes  (out_ch.name_bytes),
        .byte_count  (out_ch.byte_count),
        .name_length (out_ch.name_length),
        .found       (out_ch.found),
        .run_last    (out_ch.run_last)
    );

    // Input is only taken when the output register can take a new result.
    a_ready_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (!out_ch.valid || out_ch.ready))
        else $error("input ready while a result is stalled");

    // A hostname word carries one to four bytes.
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.found) |-> (out_ch.byte_count != 3'd0
            && out_ch.byte_count <= 3'd4 && out_ch.name_length != '0))
        else $error("hostname word with bad byte count");

    // A not-found result is a single, empty, final result.
    a_notfound_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.found) |-> (out_ch.run_last
            && out_ch.byte_count == 3'd0 && out_ch.name_bytes == 32'd0))
        else $error("malformed not-found result");

    // While a word that is not the last of its burst is offered, more words are
    // still to be read out, so input stays blocked.
    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.found && !out_ch.run_last) |-> !in_ch.ready)
        else $error("input ready in the middle of a hostname burst");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hostname_scan_extract: payload byte requests go in, hostname
// word requests come out and are compared with an in-bench scanner model.
// Depends on hse_pkg, the stream interfaces in hse_ifs and the RTL of the block.
module testbench import hse_pkg::*;;

    // Scanner phases of the in-bench model. A run is open in SCAN_RUN; SCAN_DONE
    // means a hostname was already sent and the rest of the buffer is skipped.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_DONE
    } scan_phase_t;

    // One payload byte request waiting to be driven.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } payload_req_t;

    // One hostname result request, laid out like the output channel.
    typedef struct packed {
        logic [31:0]       name_bytes;
        logic [2:0]        byte_count;
        logic [NAME_W-1:0] name_length;
        logic              found;
        logic              run_last;
    } hostname_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    hse_in_if  in_ch ();
    hse_out_if out_ch ();

    hostname_scan_extract dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Byte requests still to be driven, and hostname results still owed by the block.
    payload_req_t     pending_bytes[$];
    hostname_result_t expected_names[$];

    // Idle and stall rates in percent for the sender and receiver sides.
    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    logic byte_taken;

    // Model copy of the configuration registers.
    logic [NAME_W-1:0] cfg_min_len;
    logic [MAXL_W-1:0] cfg_max_label;

    // Model copy of the scan state. The run length saturates one above the
    // longest name so that an overlong run can never be accepted.
    logic [7:0]  name_buf [MAX_NAME];
    int          run_len;
    int          lbl_len;
    logic        dot_seen;
    logic        lbl_bad;
    logic        tail_punct;
    scan_phase_t phase;

    hostname_result_t got_name;
    hostname_result_t want_name;

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs, far above the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Only the first ten failures are printed; the rest are counted.
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endtask

    function automatic logic is_letter_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_letter_char(c) || (c >= "0" && c <= "9") || c == CHAR_DOT
            || c == CHAR_HYPHEN;
    endfunction

    function automatic void reset_run();
        run_len    = 0;
        lbl_len    = 0;
        dot_seen   = 1'b0;
        lbl_bad    = 1'b0;
        tail_punct = 1'b0;
    endfunction

    // Advances the scanner model by one accepted byte and queues every result
    // request that the byte causes.
    function automatic void scan_byte(input logic [7:0] b, input logic is_end);
        hostname_result_t r;
        logic closes;
        int k;
        int j;
        // Once a name has gone out, everything up to the buffer end is ignored.
        if (phase == SCAN_DONE)
        begin
            if (is_end)
            begin
                reset_run();
                phase = SCAN_IDLE;
            end
            return;
        end
        // A run may only open at a letter.
        if (phase != SCAN_RUN && is_letter_char(b))
        begin
            reset_run();
            phase = SCAN_RUN;
        end
        if (phase == SCAN_RUN)
        begin
            closes = 1'b1;
            if (is_name_char(b))
            begin
                if (run_len < MAX_NAME)
                    name_buf[run_len] = b;
                if (run_len <= MAX_NAME)
                    run_len++;
                if (b == CHAR_DOT)
                begin
                    // A dot closes a label; an empty or too long label spoils the run.
                    dot_seen = 1'b1;
                    if (lbl_len == 0 || lbl_len > cfg_max_label)
                        lbl_bad = 1'b1;
                    lbl_len = 0;
                end
                else if (lbl_len < 127)
                begin
                    lbl_len++;
                end
                tail_punct = (b == CHAR_DOT || b == CHAR_HYPHEN);
                // The byte marked as buffer end belongs to the run and closes it.
                closes = is_end;
            end
            if (closes)
            begin
                if (run_len >= cfg_min_len && run_len <= MAX_NAME && !tail_punct
                    && dot_seen && !lbl_bad && lbl_len >= 1 && lbl_len <= cfg_max_label)
                begin
                    // Accepted: the name leaves as words of up to four bytes.
                    for (k = 0; k < run_len && k < MAX_NAME; k += 4)
                    begin
                        r = '0;
                        for (j = 0; j < 4 && k + j < run_len && k + j < MAX_NAME; j++)
                        begin
                            r.name_bytes[8*j +: 8] = name_buf[k + j];
                            r.byte_count++;
                        end
                        r.name_length = run_len[NAME_W-1:0];
                        r.found       = 1'b1;
                        r.run_last    = (k + 4 >= run_len);
                        expected_names.push_back(r);
                    end
                    // A match on the final byte is the whole answer for the buffer.
                    phase = is_end ? SCAN_IDLE : SCAN_DONE;
                    if (is_end)
                        reset_run();
                    return;
                end
                phase = SCAN_IDLE;
            end
        end
        // The buffer ended without a hostname: one not-found request.
        if (is_end)
        begin
            reset_run();
            phase = SCAN_IDLE;
            r = '0;
            r.run_last = 1'b1;
            expected_names.push_back(r);
        end
    endfunction

    // Sender side. A request stays on the channel until it is accepted; after
    // that, the next one is offered unless this cycle is picked as idle.
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || byte_taken))
        begin
            byte_taken = 1'b0;
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid      <= 1'b1;
                in_ch.data_byte  <= pending_bytes[0].data_byte;
                in_ch.buffer_end <= pending_bytes[0].buffer_end;
                void'(pending_bytes.pop_front());
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Each accepted byte request runs through the model at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            scan_byte(in_ch.data_byte, in_ch.buffer_end);
            byte_taken = 1'b1;
        end
    end

    // Receiver side: ready is redrawn every cycle at the current stall rate.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted result is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_name = {out_ch.name_bytes, out_ch.byte_count, out_ch.name_length,
                        out_ch.found, out_ch.run_last};
            if (expected_names.size() == 0)
            begin
                note_failure($sformatf(
                    "unexpected result: bytes %h count %0d length %0d found %b last %b",
                    got_name.name_bytes, got_name.byte_count, got_name.name_length,
                    got_name.found, got_name.run_last));
            end
            else
            begin
                want_name = expected_names.pop_front();
                if (got_name !== want_name)
                    note_failure($sformatf({"result mismatch: expected bytes %h count %0d ",
                        "length %0d found %b last %b, got bytes %h count %0d length %0d ",
                        "found %b last %b"},
                        want_name.name_bytes, want_name.byte_count, want_name.name_length,
                        want_name.found, want_name.run_last,
                        got_name.name_bytes, got_name.byte_count, got_name.name_length,
                        got_name.found, got_name.run_last));
            end
        end
    end

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input logic is_write, input logic reg_idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({reg_idx, 2'b00});
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a register, mirrors it in the model and reads it back.
    task automatic write_register(input logic reg_idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] held;
        apb_transfer(1'b1, reg_idx, value, readback);
        if (reg_idx == REG_MIN_LEN)
        begin
            cfg_min_len = value[NAME_W-1:0];
            held = DATA_W'(cfg_min_len);
        end
        else
        begin
            cfg_max_label = value[MAXL_W-1:0];
            held = DATA_W'(cfg_max_label);
        end
        apb_transfer(1'b0, reg_idx, '0, readback);
        if (readback !== held)
            note_failure($sformatf("register %0d read back %h, expected %h",
                                   reg_idx, readback, held));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_end);
        payload_req_t req;
        req.data_byte  = b;
        req.buffer_end = is_end;
        pending_bytes.push_back(req);
    endtask

    task automatic push_text(input string s, input logic end_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], end_on_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] letter_byte();
        if ($urandom_range(1))
            return 8'h61 + 8'($urandom_range(25));
        return 8'h41 + 8'($urandom_range(25));
    endfunction

    // Letters dominate so that labels look like real host names.
    function automatic logic [7:0] host_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return letter_byte();
        if (pick < 9)
            return 8'h30 + 8'($urandom_range(9));
        return CHAR_HYPHEN;
    endfunction

    function automatic logic [7:0] stop_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_name_char(c));
        return c;
    endfunction

    // Noise is half arbitrary bytes, which may open short stray runs.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        return stop_byte();
    endfunction

    // One random payload buffer: some noise, usually a dotted name with random
    // content, sometimes flawed, then optionally a stop byte and trailing noise.
    // The final byte always carries buffer_end.
    task automatic queue_random_buffer(output int n_bytes);
        logic [7:0] bq[$];
        int n_labels;
        int lab;
        int cap;
        int flaw;
        int i;
        int j;
        repeat ($urandom_range(3))
            bq.push_back(noise_byte());
        if (cfg_max_label == 0)
            cap = 3;
        else
            cap = (cfg_max_label < 8) ? cfg_max_label : 8;
        n_labels = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 4);
        flaw = $urandom_range(11);
        // Flaw 3 leaves the name out: a buffer of noise only.
        if (flaw != 3)
        begin
            for (i = 0; i < n_labels; i++)
            begin
                if (i > 0)
                    bq.push_back(CHAR_DOT);
                lab = $urandom_range(1, cap);
                // Flaw 0 makes the last label one byte too long, flaw 1 empties the second one.
                if (flaw == 0 && i == n_labels - 1)
                    lab = cfg_max_label + 1;
                if (flaw == 1 && i == 1)
                    lab = 0;
                for (j = 0; j < lab; j++)
                    bq.push_back((i == 0 && j == 0) ? letter_byte() : host_byte());
            end
            // Flaw 2 leaves the name ending in punctuation.
            if (flaw == 2)
                bq.push_back($urandom_range(1) ? CHAR_DOT : CHAR_HYPHEN);
        end
        if ($urandom_range(1) || bq.size() == 0)
        begin
            bq.push_back(stop_byte());
            repeat ($urandom_range(4))
                bq.push_back(noise_byte());
        end
        for (i = 0; i < bq.size(); i++)
            push_byte(bq[i], i == bq.size() - 1);
        n_bytes = bq.size();
    endtask

    // A single run of the given length built from full-size labels, closed by
    // the buffer end. 253 bytes is the longest legal name; longer ones overflow.
    task automatic queue_long_run(input int total);
        int lab;
        int i;
        lab = 0;
        for (i = 0; i < total; i++)
        begin
            if (lab == 63)
            begin
                push_byte(CHAR_DOT, i == total - 1);
                lab = 0;
            end
            else
            begin
                push_byte(letter_byte(), i == total - 1);
                lab++;
            end
        end
    endtask

    // Waits until every byte request is taken and every result has arrived,
    // then lets the block settle.
    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || in_ch.valid || expected_names.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    // One random phase: new register values, new idle rates, random buffers, optional long run.
    task automatic run_phase(input int min_len, input int max_label, input int send_pct,
                             input int recv_pct, input int n_target, input logic with_long);
        int added;
        int n;
        write_register(REG_MIN_LEN, DATA_W'(min_len));
        write_register(REG_MAX_LABEL, DATA_W'(max_label));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        added = 0;
        while (added < n_target)
        begin
            queue_random_buffer(n);
            added += n;
        end
        if (with_long)
            queue_long_run(253);
        wait_for_drain();
    endtask

    // Main sequence: reset, directed buffers at reset settings, then random
    // phases across register extremes and idle profiles, then the verdict.
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.buffer_end = 1'b0;
        out_ch.ready     = 1'b0;
        byte_taken       = 1'b0;
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        cfg_min_len      = MIN_LEN_RESET;
        cfg_max_label    = MAX_LABEL_RESET;
        phase            = SCAN_IDLE;
        reset_run();

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset register values, no idling.
        // A name closed by the buffer end on its last byte.
        push_text("ab.cde", 1'b1);
        // A name closed by a stop byte; the rest of the buffer is skipped silently.
        push_byte(8'hFF, 1'b0);
        push_text("x1.com", 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("Zz", 1'b0);
        push_byte(8'h20, 1'b1);
        // A digit cannot open a run, and a trailing hyphen spoils it.
        push_text("9a-", 1'b1);
        // A buffer of one punctuation byte.
        push_byte(CHAR_DOT, 1'b1);
        wait_for_drain();

        // Random part: tiny labels with a busy sender, the longest name with a
        // busy receiver, zeroed registers with light idling on both sides, then
        // random settings at full speed.
        run_phase(1, 1, 82, 0, 35, 1'b0);
        run_phase(253, 63, 0, 82, 25, 1'b1);
        run_phase(0, 0, 14, 14, 25, 1'b0);
        run_phase($urandom_range(1, 16), $urandom_range(2, 12), 0, 0, 45, 1'b0);

        wait_for_drain();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
